FILE: rtl/pcw_pkg.sv
`timescale 1ns / 1ps

package pcw_pkg;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_LEN  = 3'd1,
      PH_TYPE = 3'd2,
      PH_DATA = 3'd3,
      PH_CRC  = 3'd4,
      PH_END  = 3'd5
   } pcw_phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_IDAT  = 2'd1,
      KIND_IEND  = 2'd2
   } pcw_kind_type;

   localparam logic [7:0]  KEY_RESET = 8'd42;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
   localparam logic [2:0]  LAST_SIG_INDEX = 3'd7;
   localparam logic [2:0]  LAST_FIELD_INDEX = 3'd3;

   localparam logic [7:0] SIG_BYTES [8] = '{
      8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
   };

   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } pcw_req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  region;
      logic [1:0]  chunk_kind;
      logic [31:0] chunk_length;
      logic        bad_signature;
      logic        end_found;
   } pcw_rsp_type;

endpackage

FILE: rtl/png_chunk_walker_xor_unit.sv
`timescale 1ns / 1ps

// Walks a PNG byte stream at one byte per clock cycle while the result side
// does not stall: each accepted transaction updates the chunk walker and its
// result lands in the output register on the same edge, so rsp_valid rises in
// the cycle after the byte is taken. The walker state update is the only loop,
// so back-to-back bytes are accepted for as long as the result side does not
// stall. The key is written through the csr_ port, which is always ready;
// write it only while no transaction is in flight.
module png_chunk_walker_xor_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcw_pkg::pcw_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcw_pkg::pcw_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_wdata
);
   import pcw_pkg::*;

   logic [7:0]  key_ff;
   logic        step;
   logic        out_busy;
   pcw_rsp_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else if (csr_valid && csr_ready) begin
         key_ff <= csr_wdata;
      end
   end

   assign req_stall = out_busy;
   assign step      = req_valid && !out_busy;

   pcw_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .xor_key  (key_ff),
      .req_data (req_data),
      .result   (result)
   );

   pcw_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_data (result),
      .busy      (out_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/pcw_walker.sv
`timescale 1ns / 1ps

module pcw_walker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           xor_key,
   input  pcw_pkg::pcw_req_type req_data,
   output pcw_pkg::pcw_rsp_type result
);
   import pcw_pkg::*;

   pcw_phase_type phase_ff, phase_in;
   logic [2:0]    byte_index_ff, byte_index_in;
   logic [31:0]   length_ff, length_in;
   logic [31:0]   remaining_ff, remaining_in;
   logic [23:0]   type_shift_ff, type_shift_in;
   pcw_kind_type  kind_ff, kind_in;
   logic          sig_error_ff, sig_error_in;
   logic          done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIG;
         byte_index_ff <= '0;
         length_ff     <= '0;
         remaining_ff  <= '0;
         type_shift_ff <= '0;
         kind_ff       <= KIND_OTHER;
         sig_error_ff  <= 1'b0;
         done_ff       <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         length_ff     <= length_in;
         remaining_ff  <= remaining_in;
         type_shift_ff <= type_shift_in;
         kind_ff       <= kind_in;
         sig_error_ff  <= sig_error_in;
         done_ff       <= done_in;
      end
   end

   always_comb begin
      pcw_phase_type cur_phase;
      logic [2:0]    cur_index;
      logic [31:0]   cur_length;
      logic [31:0]   cur_remaining;
      logic [23:0]   cur_type;
      pcw_kind_type  cur_kind;
      logic          cur_error;
      logic          cur_done;
      logic [7:0]    b;
      logic [7:0]    ob;
      logic [31:0]   full_type;
      logic [2:0]    region;

      b = req_data.in_byte;
      // A restart clears the parse before this byte is looked at.
      if (req_data.restart) begin
         cur_phase     = PH_SIG;
         cur_index     = '0;
         cur_length    = '0;
         cur_remaining = '0;
         cur_type      = '0;
         cur_kind      = KIND_OTHER;
         cur_error     = 1'b0;
         cur_done      = 1'b0;
      end else begin
         cur_phase     = phase_ff;
         cur_index     = byte_index_ff;
         cur_length    = length_ff;
         cur_remaining = remaining_ff;
         cur_type      = type_shift_ff;
         cur_kind      = kind_ff;
         cur_error     = sig_error_ff;
         cur_done      = done_ff;
      end

      phase_in      = cur_phase;
      byte_index_in = cur_index;
      length_in     = cur_length;
      remaining_in  = cur_remaining;
      type_shift_in = cur_type;
      kind_in       = cur_kind;
      sig_error_in  = cur_error;
      done_in       = cur_done;
      ob            = b;
      region        = cur_phase;
      full_type     = {cur_type, b};

      case (cur_phase)
         PH_SIG: begin
            if (!cur_error) begin
               if (b != SIG_BYTES[cur_index]) begin
                  sig_error_in = 1'b1;
               end else if (cur_index == LAST_SIG_INDEX) begin
                  phase_in      = PH_LEN;
                  byte_index_in = '0;
               end else begin
                  byte_index_in = cur_index + 3'd1;
               end
            end
         end
         PH_LEN: begin
            if (cur_index == '0) begin
               length_in = {24'd0, b};
               kind_in   = KIND_OTHER;
            end else begin
               length_in = {cur_length[23:0], b};
            end
            if (cur_index == LAST_FIELD_INDEX) begin
               phase_in      = PH_TYPE;
               byte_index_in = '0;
               type_shift_in = '0;
            end else begin
               byte_index_in = cur_index + 3'd1;
            end
         end
         PH_TYPE: begin
            type_shift_in = full_type[23:0];
            if (cur_index == LAST_FIELD_INDEX) begin
               if (full_type == TYPE_IDAT) begin
                  kind_in = KIND_IDAT;
               end else if (full_type == TYPE_IEND) begin
                  kind_in = KIND_IEND;
               end else begin
                  kind_in = KIND_OTHER;
               end
               remaining_in  = cur_length;
               byte_index_in = '0;
               phase_in      = (cur_length == '0) ? PH_CRC : PH_DATA;
            end else begin
               byte_index_in = cur_index + 3'd1;
            end
         end
         PH_DATA: begin
            if (cur_kind == KIND_IDAT) begin
               ob = b ^ xor_key;
            end
            remaining_in = cur_remaining - 32'd1;
            if (cur_remaining == 32'd1) begin
               phase_in      = PH_CRC;
               byte_index_in = '0;
            end
         end
         PH_CRC: begin
            if (cur_index == LAST_FIELD_INDEX) begin
               byte_index_in = '0;
               if (cur_kind == KIND_IEND) begin
                  phase_in = PH_END;
                  done_in  = 1'b1;
               end else begin
                  phase_in = PH_LEN;
               end
            end else begin
               byte_index_in = cur_index + 3'd1;
            end
         end
         PH_END: begin
         end
         default: begin
            phase_in = PH_END;
            region   = PH_END;
         end
      endcase

      result.out_byte      = ob;
      result.region        = region;
      result.chunk_kind    = kind_in;
      result.chunk_length  = length_in;
      result.bad_signature = sig_error_in;
      result.end_found     = done_in;
   end

   a_error_holds_sig: assert property (@(posedge clock) disable iff (reset)
      sig_error_ff |-> phase_ff == PH_SIG)
      else $error("signature error outside the signature region");

   a_done_in_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> phase_ff == PH_END)
      else $error("end flag set outside the after-end region");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remaining_ff != '0)
      else $error("data region entered with no bytes remaining");

   a_field_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN || phase_ff == PH_TYPE || phase_ff == PH_CRC)
      |-> byte_index_ff <= LAST_FIELD_INDEX)
      else $error("field byte index out of range");

endmodule

FILE: rtl/pcw_out_reg.sv
`timescale 1ns / 1ps

module pcw_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  pcw_pkg::pcw_rsp_type load_data,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcw_pkg::pcw_rsp_type rsp_data
);
   import pcw_pkg::*;

   logic        valid_ff;
   pcw_rsp_type data_ff;

   // The register can take a new result in the same cycle its old one leaves.
   assign busy = valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
